// File: hdl/tdb_pkg.sv
// ----------------------------------------------------------------------------
// tdb_pkg
// Shared types and constants for the tick divider with buzzer.
// ----------------------------------------------------------------------------
`default_nettype none

package tdb_pkg;

    // millisecond divider register
    localparam int TPM_W     = 5;
    localparam int TPM_MIN   = 1;
    localparam int TPM_MAX   = 20;
    localparam int TPM_RESET = 10;

    // divider widths, sized for the largest reload
    localparam int DIV_1MS_W   = 5;
    localparam int DIV_2MS_W   = 6;
    localparam int DIV_10MS_W  = 8;
    localparam int DIV_100MS_W = 11;
    localparam int DIV_1S_W    = 15;

    localparam int MS_PER_2MS   = 2;
    localparam int MS_PER_10MS  = 10;
    localparam int MS_PER_100MS = 100;
    localparam int MS_PER_1S    = 1000;

    // enable pin drops this many milliseconds before the buzzer ends
    localparam int BUZZ_TAIL_MS = 200;
    localparam int BUZZ_TAIL_W  = 12;

    localparam int COUNT_W   = 32;
    localparam int SHORT_W   = 16;
    localparam int DUR_W     = 16;
    localparam int HALF_W    = 8;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 104;

    typedef enum logic [1:0] {
        KIND_TICK        = 2'd0,
        KIND_BUZZ_START  = 2'd1,
        KIND_CLR_KEY     = 2'd2,
        KIND_CLR_UV      = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic               uv_on;
        logic               uv_check_enable;
        logic               key_counting;
        logic [DUR_W-1:0]   buzzer_duration;
        logic [HALF_W-1:0]  buzzer_half_period;
    } item_t;

    typedef struct packed {
        logic               pulse_1ms;
        logic               pulse_2ms;
        logic               pulse_10ms;
        logic               pulse_100ms;
        logic               pulse_1s;
        logic               uv_check_pulse;
        logic [COUNT_W-1:0] time_ms;
        logic [COUNT_W-1:0] time_s;
        logic [SHORT_W-1:0] uv_interval;
        logic [SHORT_W-1:0] key_ticks;
    } tb_out_t;

    typedef struct packed {
        logic enable_pin;
        logic tone_pin;
    } buzz_out_t;

endpackage

`default_nettype wire

// File: hdl/tdb_timebase.sv
// ----------------------------------------------------------------------------
// tdb_timebase
// Five reload-down dividers plus millisecond, second, uv and key counters.
// ----------------------------------------------------------------------------
`default_nettype none

module tdb_timebase
    import tdb_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [TPM_W-1:0] tpm,
    input  wire logic             step,
    input  wire item_t            item,
    output tb_out_t               result
);

    logic [DIV_1MS_W-1:0]   div_1ms_reg,   div_1ms_next;
    logic [DIV_2MS_W-1:0]   div_2ms_reg,   div_2ms_next;
    logic [DIV_10MS_W-1:0]  div_10ms_reg,  div_10ms_next;
    logic [DIV_100MS_W-1:0] div_100ms_reg, div_100ms_next;
    logic [DIV_1S_W-1:0]    div_1s_reg,    div_1s_next;
    logic [COUNT_W-1:0]     ms_reg,        ms_next;
    logic [COUNT_W-1:0]     sec_reg,       sec_next;
    logic [SHORT_W-1:0]     uv_reg,        uv_next;
    logic [SHORT_W-1:0]     key_reg,       key_next;

    logic [DIV_1MS_W-1:0]   rl_1ms;
    logic [DIV_2MS_W-1:0]   rl_2ms;
    logic [DIV_10MS_W-1:0]  rl_10ms;
    logic [DIV_100MS_W-1:0] rl_100ms;
    logic [DIV_1S_W-1:0]    rl_1s;

    logic [DIV_1MS_W-1:0]   dec_1ms;
    logic [DIV_2MS_W-1:0]   dec_2ms;
    logic [DIV_10MS_W-1:0]  dec_10ms;
    logic [DIV_100MS_W-1:0] dec_100ms;
    logic [DIV_1S_W-1:0]    dec_1s;
    logic [COUNT_W-1:0]     ms_inc;

    logic p1, p2, p10, p100, p1s, pchk;

    // reloads follow the current register value
    assign rl_1ms   = tpm;
    assign rl_2ms   = DIV_2MS_W'(tpm) * DIV_2MS_W'(MS_PER_2MS);
    assign rl_10ms  = DIV_10MS_W'(tpm) * DIV_10MS_W'(MS_PER_10MS);
    assign rl_100ms = DIV_100MS_W'(tpm) * DIV_100MS_W'(MS_PER_100MS);
    assign rl_1s    = DIV_1S_W'(tpm) * DIV_1S_W'(MS_PER_1S);

    assign dec_1ms   = div_1ms_reg - 1'b1;
    assign dec_2ms   = div_2ms_reg - 1'b1;
    assign dec_10ms  = div_10ms_reg - 1'b1;
    assign dec_100ms = div_100ms_reg - 1'b1;
    assign dec_1s    = div_1s_reg - 1'b1;
    assign ms_inc    = ms_reg + 1'b1;

    always_comb begin
        div_1ms_next   = div_1ms_reg;
        div_2ms_next   = div_2ms_reg;
        div_10ms_next  = div_10ms_reg;
        div_100ms_next = div_100ms_reg;
        div_1s_next    = div_1s_reg;
        ms_next        = ms_reg;
        sec_next       = sec_reg;
        uv_next        = uv_reg;
        key_next       = key_reg;
        p1             = 1'b0;
        p2             = 1'b0;
        p10            = 1'b0;
        p100           = 1'b0;
        p1s            = 1'b0;
        pchk           = 1'b0;
        if (step) begin
            unique case (item.kind)
                KIND_TICK: begin
                    p1   = (dec_1ms == '0);
                    p2   = (dec_2ms == '0);
                    p10  = (dec_10ms == '0);
                    p100 = (dec_100ms == '0);
                    p1s  = (dec_1s == '0);
                    div_1ms_next   = p1   ? rl_1ms   : dec_1ms;
                    div_2ms_next   = p2   ? rl_2ms   : dec_2ms;
                    div_10ms_next  = p10  ? rl_10ms  : dec_10ms;
                    div_100ms_next = p100 ? rl_100ms : dec_100ms;
                    div_1s_next    = p1s  ? rl_1s    : dec_1s;
                    // millisecond time skips the all-ones value
                    if (p1) begin
                        ms_next = (ms_inc == '1) ? '0 : ms_inc;
                    end
                    if (p1s) begin
                        sec_next = sec_reg + 1'b1;
                        if (item.uv_on) begin
                            uv_next = uv_reg + 1'b1;
                            pchk    = item.uv_check_enable;
                        end
                    end
                    if (item.key_counting) begin
                        key_next = key_reg + 1'b1;
                    end
                end
                KIND_BUZZ_START: begin
                end
                KIND_CLR_KEY: begin
                    key_next = '0;
                end
                KIND_CLR_UV: begin
                    uv_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_1ms_reg   <= DIV_1MS_W'(TPM_RESET);
            div_2ms_reg   <= DIV_2MS_W'(MS_PER_2MS * TPM_RESET);
            div_10ms_reg  <= DIV_10MS_W'(MS_PER_10MS * TPM_RESET);
            div_100ms_reg <= DIV_100MS_W'(MS_PER_100MS * TPM_RESET);
            div_1s_reg    <= DIV_1S_W'(MS_PER_1S * TPM_RESET);
            ms_reg        <= '0;
            sec_reg       <= '0;
            uv_reg        <= '0;
            key_reg       <= '0;
        end else begin
            div_1ms_reg   <= div_1ms_next;
            div_2ms_reg   <= div_2ms_next;
            div_10ms_reg  <= div_10ms_next;
            div_100ms_reg <= div_100ms_next;
            div_1s_reg    <= div_1s_next;
            ms_reg        <= ms_next;
            sec_reg       <= sec_next;
            uv_reg        <= uv_next;
            key_reg       <= key_next;
        end
    end

    assign result.pulse_1ms      = p1;
    assign result.pulse_2ms      = p2;
    assign result.pulse_10ms     = p10;
    assign result.pulse_100ms    = p100;
    assign result.pulse_1s       = p1s;
    assign result.uv_check_pulse = pchk;
    assign result.time_ms        = ms_next;
    assign result.time_s         = sec_next;
    assign result.uv_interval    = uv_next;
    assign result.key_ticks      = key_next;

    a_div_1ms_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        div_1ms_reg != '0)
        else $error("1 ms divider reached zero without reload");

    a_div_1s_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        div_1s_reg != '0)
        else $error("1 s divider reached zero without reload");

    a_ms_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        ms_reg != '1)
        else $error("millisecond time holds all-ones");

    a_chk_needs_sec: assert property (@(posedge aclk) disable iff (!aresetn)
        pchk |-> p1s && item.uv_on)
        else $error("uv check pulse without uv second");

endmodule

`default_nettype wire

// File: hdl/tdb_buzzer.sv
// ----------------------------------------------------------------------------
// tdb_buzzer
// Buzzer run counter, tone half-period counter and pin levels.
// ----------------------------------------------------------------------------
`default_nettype none

module tdb_buzzer
    import tdb_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [TPM_W-1:0] tpm,
    input  wire logic             step,
    input  wire item_t            item,
    output buzz_out_t             pins
);

    logic [DUR_W-1:0]       rem_reg,  rem_next;
    logic [HALF_W-1:0]      half_reg, half_next;
    logic [HALF_W-1:0]      rel_reg,  rel_next;
    logic                   en_reg,   en_next;
    logic                   tone_reg, tone_next;

    logic [DUR_W-1:0]       rem_dec;
    logic [HALF_W-1:0]      half_dec;
    logic [BUZZ_TAIL_W-1:0] tail;

    assign rem_dec  = rem_reg - 1'b1;
    assign half_dec = half_reg - 1'b1;
    assign tail     = BUZZ_TAIL_W'(tpm) * BUZZ_TAIL_W'(BUZZ_TAIL_MS);

    always_comb begin
        rem_next  = rem_reg;
        half_next = half_reg;
        rel_next  = rel_reg;
        en_next   = en_reg;
        tone_next = tone_reg;
        if (step) begin
            unique case (item.kind)
                KIND_TICK: begin
                    if (rem_reg != '0) begin
                        // half period counter wraps through zero
                        if (half_dec == '0) begin
                            tone_next = ~tone_reg;
                            half_next = rel_reg;
                        end else begin
                            half_next = half_dec;
                        end
                        rem_next = rem_dec;
                        if (rem_dec == '0) begin
                            half_next = '0;
                            en_next   = 1'b0;
                            tone_next = 1'b0;
                        end else if (rem_dec == DUR_W'(tail)) begin
                            en_next = 1'b0;
                        end
                    end
                end
                KIND_BUZZ_START: begin
                    rem_next  = item.buzzer_duration;
                    rel_next  = item.buzzer_half_period;
                    half_next = (item.buzzer_duration != '0) ? item.buzzer_half_period : '0;
                    en_next   = (item.buzzer_duration != '0);
                    tone_next = 1'b0;
                end
                KIND_CLR_KEY, KIND_CLR_UV: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg  <= '0;
            half_reg <= '0;
            rel_reg  <= '0;
            en_reg   <= 1'b0;
            tone_reg <= 1'b0;
        end else begin
            rem_reg  <= rem_next;
            half_reg <= half_next;
            rel_reg  <= rel_next;
            en_reg   <= en_next;
            tone_reg <= tone_next;
        end
    end

    assign pins.enable_pin = en_next;
    assign pins.tone_pin   = tone_next;

    a_en_while_running: assert property (@(posedge aclk) disable iff (!aresetn)
        en_reg |-> rem_reg != '0)
        else $error("enable pin high with buzzer idle");

    a_tone_while_running: assert property (@(posedge aclk) disable iff (!aresetn)
        tone_reg |-> rem_reg != '0)
        else $error("tone pin high with buzzer idle");

    a_idle_half_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg == '0 |-> half_reg == '0)
        else $error("half period counter left over after buzzer end");

endmodule

`default_nettype wire

// File: hdl/tick_divider_with_buzzer.sv
// ----------------------------------------------------------------------------
// tick_divider_with_buzzer
// Base tick divider with time counters and a timed buzzer driver.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tuser: kind; s_tdata: flags, buzzer setup
//  m_        out  m_tvalid/m_tready  m_tdata: pulses, counters, buzzer pins
//  cfg_      in   cfg_we             cfg_wdata: ticks_per_ms, clamped to 1..20
//
//  one transaction per clock while m_ does not stall; a transaction waits in the
//  input register and moves to the output register once that is free or read
//  all counter state advances in the cycle the item moves to the output
//  register, so a stall on m_ holds the item and the state together
//  reset clears the dividers to their ten-ticks-per-ms values and all counters
// ----------------------------------------------------------------------------
`default_nettype none

module tick_divider_with_buzzer
    import tdb_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 cfg_we,
    input  wire logic [TPM_W-1:0]     cfg_wdata,

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [1:0] kind
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    // [0] uv_on, [1] uv_check_enable, [2] key_counting,
    // [18:3] buzzer_duration, [26:19] buzzer_half_period, [31:27] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [0] pulse_1ms, [1] pulse_2ms, [2] pulse_10ms, [3] pulse_100ms,
    // [4] pulse_1s, [5] uv_check_pulse, [37:6] time_ms, [69:38] time_s,
    // [85:70] uv_interval, [101:86] key_ticks, [102] buzzer_enable_pin,
    // [103] buzzer_tone_pin
    output logic [M_TDATA_W-1:0]      m_tdata
);

    logic [TPM_W-1:0]     tpm_reg;
    logic                 in_vld_reg,  in_vld_next;
    item_t                in_item_reg;
    logic                 out_vld_reg, out_vld_next;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic                 s_fire;
    logic                 step;
    item_t                s_item;
    tb_out_t              tb_res;
    buzz_out_t            buzz_res;

    // register write with clamping into the legal range
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpm_reg <= TPM_W'(TPM_RESET);
        end else if (cfg_we) begin
            if (cfg_wdata < TPM_W'(TPM_MIN)) begin
                tpm_reg <= TPM_W'(TPM_MIN);
            end else if (cfg_wdata > TPM_W'(TPM_MAX)) begin
                tpm_reg <= TPM_W'(TPM_MAX);
            end else begin
                tpm_reg <= cfg_wdata;
            end
        end
    end

    assign step     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || step;
    assign s_fire   = s_tvalid && s_tready;

    assign s_item.kind               = kind_t'(s_tuser);
    assign s_item.uv_on              = s_tdata[0];
    assign s_item.uv_check_enable    = s_tdata[1];
    assign s_item.key_counting       = s_tdata[2];
    assign s_item.buzzer_duration    = s_tdata[18:3];
    assign s_item.buzzer_half_period = s_tdata[26:19];

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_fire) begin
            in_vld_next = 1'b1;
        end else if (step) begin
            in_vld_next = 1'b0;
        end
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (step) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= s_item;
        end
        if (step) begin
            out_data_reg <= {buzz_res.tone_pin, buzz_res.enable_pin,
                             tb_res.key_ticks, tb_res.uv_interval,
                             tb_res.time_s, tb_res.time_ms,
                             tb_res.uv_check_pulse, tb_res.pulse_1s,
                             tb_res.pulse_100ms, tb_res.pulse_10ms,
                             tb_res.pulse_2ms, tb_res.pulse_1ms};
        end
    end

    tdb_timebase u_timebase (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tpm     (tpm_reg),
        .step    (step),
        .item    (in_item_reg),
        .result  (tb_res)
    );

    tdb_buzzer u_buzzer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tpm     (tpm_reg),
        .step    (step),
        .item    (in_item_reg),
        .pins    (buzz_res)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    a_step_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> out_vld_reg)
        else $error("processed transaction missing from output register");

    a_tpm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tpm_reg >= TPM_W'(TPM_MIN) && tpm_reg <= TPM_W'(TPM_MAX))
        else $error("ticks per ms out of range");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !step |=> in_vld_reg && $stable(in_item_reg))
        else $error("held input transaction lost or changed");

endmodule

`default_nettype wire

// File: sim/tb_tick_divider_with_buzzer.sv
// ----------------------------------------------------------------------------
// tb_tick_divider_with_buzzer
// Self-checking bench for the tick divider. A timebase scoreboard tracks the
// divider, counter and buzzer state for every accepted input and compares
// each output transaction field by field. Stimulus is a short directed
// opening, a short tick soak at one tick per ms, then random phases under
// several divider settings with random stalls.
// ----------------------------------------------------------------------------

module tb_tick_divider_with_buzzer;
    import tdb_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam logic [COUNT_W-1:0] MS_SKIP = '1;

    // output payload, lowest bit last
    typedef struct packed {
        logic               tone_pin;
        logic               enable_pin;
        logic [SHORT_W-1:0] key_ticks;
        logic [SHORT_W-1:0] uv_interval;
        logic [COUNT_W-1:0] time_s;
        logic [COUNT_W-1:0] time_ms;
        logic               uv_check_pulse;
        logic               pulse_1s;
        logic               pulse_100ms;
        logic               pulse_10ms;
        logic               pulse_2ms;
        logic               pulse_1ms;
    } res_t;

    class timebase_scoreboard;
        bit [TPM_W-1:0]       rate;
        bit [DIV_1MS_W-1:0]   div_1ms;
        bit [DIV_2MS_W-1:0]   div_2ms;
        bit [DIV_10MS_W-1:0]  div_10ms;
        bit [DIV_100MS_W-1:0] div_100ms;
        bit [DIV_1S_W-1:0]    div_1s;
        bit [COUNT_W-1:0]     ms_time;
        bit [COUNT_W-1:0]     sec_time;
        bit [SHORT_W-1:0]     uv_secs;
        bit [SHORT_W-1:0]     key_cnt;
        bit [DUR_W-1:0]       buzz_left;
        bit [HALF_W-1:0]      half_cnt;
        bit [HALF_W-1:0]      half_reload;
        bit                   en_pin;
        bit                   tone_pin;
        res_t                 results_due[$];
        int unsigned          mismatches;

        function new();
            rate        = TPM_W'(TPM_RESET);
            div_1ms     = DIV_1MS_W'(TPM_RESET);
            div_2ms     = DIV_2MS_W'(MS_PER_2MS * TPM_RESET);
            div_10ms    = DIV_10MS_W'(MS_PER_10MS * TPM_RESET);
            div_100ms   = DIV_100MS_W'(MS_PER_100MS * TPM_RESET);
            div_1s      = DIV_1S_W'(MS_PER_1S * TPM_RESET);
            ms_time     = '0;
            sec_time    = '0;
            uv_secs     = '0;
            key_cnt     = '0;
            buzz_left   = '0;
            half_cnt    = '0;
            half_reload = '0;
            en_pin      = 1'b0;
            tone_pin    = 1'b0;
            mismatches  = 0;
        endfunction

        function void set_rate(logic [TPM_W-1:0] wr);
            if (wr < TPM_MIN) begin
                rate = TPM_W'(TPM_MIN);
            end else if (wr > TPM_MAX) begin
                rate = TPM_W'(TPM_MAX);
            end else begin
                rate = wr;
            end
        endfunction

        function int unsigned pending();
            return results_due.size();
        endfunction

        // advance the timebase by one accepted transaction
        function void apply_item(item_t it);
            res_t want;
            want = '0;
            case (it.kind)
                KIND_TICK: begin
                    // dividers reload from the current rate only when they run out
                    want.pulse_1ms   = (div_1ms == 1);
                    div_1ms          = want.pulse_1ms ? DIV_1MS_W'(rate) : div_1ms - 1'b1;
                    want.pulse_2ms   = (div_2ms == 1);
                    div_2ms          = want.pulse_2ms ?
                                       DIV_2MS_W'(MS_PER_2MS * rate) : div_2ms - 1'b1;
                    want.pulse_10ms  = (div_10ms == 1);
                    div_10ms         = want.pulse_10ms ?
                                       DIV_10MS_W'(MS_PER_10MS * rate) : div_10ms - 1'b1;
                    want.pulse_100ms = (div_100ms == 1);
                    div_100ms        = want.pulse_100ms ?
                                       DIV_100MS_W'(MS_PER_100MS * rate) : div_100ms - 1'b1;
                    want.pulse_1s    = (div_1s == 1);
                    div_1s           = want.pulse_1s ?
                                       DIV_1S_W'(MS_PER_1S * rate) : div_1s - 1'b1;
                    if (want.pulse_1ms) begin
                        ms_time = ms_time + 1'b1;
                        if (ms_time == MS_SKIP) begin
                            ms_time = '0;
                        end
                    end
                    if (want.pulse_1s) begin
                        if (it.uv_on) begin
                            uv_secs = uv_secs + 1'b1;
                            want.uv_check_pulse = it.uv_check_enable;
                        end
                        sec_time = sec_time + 1'b1;
                    end
                    if (it.key_counting) begin
                        key_cnt = key_cnt + 1'b1;
                    end
                    if (buzz_left != 0) begin
                        half_cnt = half_cnt - 1'b1;
                        if (half_cnt == 0) begin
                            tone_pin = ~tone_pin;
                            half_cnt = half_reload;
                        end
                        buzz_left = buzz_left - 1'b1;
                        if (buzz_left == 0) begin
                            half_cnt = '0;
                            en_pin   = 1'b0;
                            tone_pin = 1'b0;
                        end else if (int'(buzz_left) == BUZZ_TAIL_MS * int'(rate)) begin
                            en_pin = 1'b0;
                        end
                    end
                end
                KIND_BUZZ_START: begin
                    buzz_left   = it.buzzer_duration;
                    half_reload = it.buzzer_half_period;
                    half_cnt    = (it.buzzer_duration != 0) ? it.buzzer_half_period : '0;
                    en_pin      = (it.buzzer_duration != 0);
                    tone_pin    = 1'b0;
                end
                KIND_CLR_KEY: begin
                    key_cnt = '0;
                end
                default: begin
                    uv_secs = '0;
                end
            endcase
            want.time_ms     = ms_time;
            want.time_s      = sec_time;
            want.uv_interval = uv_secs;
            want.key_ticks   = key_cnt;
            want.enable_pin  = en_pin;
            want.tone_pin    = tone_pin;
            results_due.push_back(want);
        endfunction

        function void check_field(string name, logic [COUNT_W-1:0] want,
                                  logic [COUNT_W-1:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch on %s: expected 0x%0h, got 0x%0h", name, want, got);
                end
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("output transaction with nothing expected: 0x%0h", got);
                end
                return;
            end
            want = results_due.pop_front();
            check_field("pulse_1ms", want.pulse_1ms, got.pulse_1ms);
            check_field("pulse_2ms", want.pulse_2ms, got.pulse_2ms);
            check_field("pulse_10ms", want.pulse_10ms, got.pulse_10ms);
            check_field("pulse_100ms", want.pulse_100ms, got.pulse_100ms);
            check_field("pulse_1s", want.pulse_1s, got.pulse_1s);
            check_field("uv_check_pulse", want.uv_check_pulse, got.uv_check_pulse);
            check_field("time_ms", want.time_ms, got.time_ms);
            check_field("time_s", want.time_s, got.time_s);
            check_field("uv_interval", want.uv_interval, got.uv_interval);
            check_field("key_ticks", want.key_ticks, got.key_ticks);
            check_field("buzzer_enable_pin", want.enable_pin, got.enable_pin);
            check_field("buzzer_tone_pin", want.tone_pin, got.tone_pin);
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [TPM_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TUSER_W-1:0] s_tuser;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    timebase_scoreboard sb;
    int unsigned        tx_rate;
    int unsigned        rx_rate;
    int unsigned        cycles;

    tick_divider_with_buzzer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // pct is the chance in percent that this transaction waits at all
    function automatic int unsigned draw_gap(int unsigned pct);
        if ($urandom_range(0, 99) < pct) begin
            return $urandom_range(0, 17);
        end
        return 0;
    endfunction

    function automatic item_t mk_item(kind_t k, logic [2:0] flags, logic [DUR_W-1:0] dur,
                                      logic [HALF_W-1:0] half);
        item_t it;
        it.kind               = k;
        it.uv_on              = flags[0];
        it.uv_check_enable    = flags[1];
        it.key_counting       = flags[2];
        it.buzzer_duration    = dur;
        it.buzzer_half_period = half;
        return it;
    endfunction

    function automatic item_t rand_item(int unsigned tick_pct);
        item_t       it;
        int unsigned sel;
        int unsigned tail;
        tail = BUZZ_TAIL_MS * int'(sb.rate);
        if ($urandom_range(0, 99) < tick_pct) begin
            it.kind = KIND_TICK;
        end else begin
            sel = $urandom_range(0, 9);
            it.kind = (sel < 4) ? KIND_BUZZ_START : (sel < 7) ? KIND_CLR_KEY : KIND_CLR_UV;
        end
        it.uv_on           = ($urandom_range(0, 3) != 0);
        it.uv_check_enable = ($urandom_range(0, 3) != 0);
        it.key_counting    = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0:       it.buzzer_duration = '0;
            1:       it.buzzer_duration = '1;
            2:       it.buzzer_duration = DUR_W'($urandom_range(1, tail));
            3, 4:    it.buzzer_duration = DUR_W'(tail + $urandom_range(1, 40));
            5:       it.buzzer_duration = DUR_W'($urandom_range(0, 65535));
            default: it.buzzer_duration = DUR_W'($urandom_range(1, 30));
        endcase
        case ($urandom_range(0, 7))
            0:       it.buzzer_half_period = '0;
            1:       it.buzzer_half_period = '1;
            2:       it.buzzer_half_period = HALF_W'($urandom_range(0, 255));
            default: it.buzzer_half_period = HALF_W'($urandom_range(1, 6));
        endcase
        return it;
    endfunction

    // entered and left at a falling edge
    task automatic send_item(item_t it);
        int unsigned gap;
        gap = draw_gap(tx_rate);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {5'd0, it.buzzer_half_period, it.buzzer_duration, it.key_counting,
                     it.uv_check_enable, it.uv_on};
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.apply_item(it);
        @(negedge aclk);
    endtask

    task automatic wait_drained(int unsigned extra);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (extra) @(negedge aclk);
    endtask

    task automatic write_rate(logic [TPM_W-1:0] v);
        wait_drained(4);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        sb.set_rate(v);
    endtask

    task automatic run_items(int unsigned n, int unsigned tick_pct, bit vary_pace);
        for (int unsigned i = 0; i < n; i++) begin
            if (vary_pace && (i % 64 == 0)) begin
                case ($urandom_range(0, 3))
                    0:       begin tx_rate = 0;   rx_rate = 0;   end
                    1:       begin tx_rate = 100; rx_rate = 0;   end
                    2:       begin tx_rate = 0;   rx_rate = 100; end
                    default: begin tx_rate = 60;  rx_rate = 60;  end
                endcase
            end
            // now and then let every output transaction come back before going on
            if (vary_pace && $urandom_range(0, 99) == 0) begin
                wait_drained(0);
            end
            send_item(rand_item(tick_pct));
        end
    endtask

    initial begin : result_sink
        int unsigned stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            stall = draw_gap(rx_rate);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            sb.check_result(res_t'(m_tdata));
        end
    end

    initial begin : watchdog
        cycles = 0;
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb_tick_divider_with_buzzer failed");
        $finish;
    end

    initial begin : stimulus
        item_t            opening[$];
        logic [TPM_W-1:0] phase_rate [7];
        int unsigned      phase_len [7];

        sb        = new();
        tx_rate   = 50;
        rx_rate   = 50;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tuser   = '0;
        s_tdata   = '0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset rate of ten ticks per ms, so the enable pin drops at 2000 left
        opening.push_back(mk_item(KIND_TICK, 3'b000, '0, '0));
        opening.push_back(mk_item(KIND_TICK, 3'b111, '0, '0));
        opening.push_back(mk_item(KIND_CLR_KEY, 3'b111, '1, '1));
        opening.push_back(mk_item(KIND_CLR_UV, 3'b111, '1, '1));
        opening.push_back(mk_item(KIND_BUZZ_START, 3'b000, '0, '0));
        opening.push_back(mk_item(KIND_TICK, 3'b100, '0, '0));
        opening.push_back(mk_item(KIND_BUZZ_START, 3'b000, '1, '1));
        opening.push_back(mk_item(KIND_TICK, 3'b000, '0, '0));
        opening.push_back(mk_item(KIND_TICK, 3'b000, '0, '0));
        // restart while running, zero half period, then cross the enable cutoff
        opening.push_back(mk_item(KIND_BUZZ_START, 3'b000, 16'd2003, '0));
        repeat (4) opening.push_back(mk_item(KIND_TICK, 3'b100, '0, '0));
        // duration inside the tail keeps the enable pin up to the end
        opening.push_back(mk_item(KIND_BUZZ_START, 3'b000, 16'd3, 8'd1));
        repeat (4) opening.push_back(mk_item(KIND_TICK, 3'b011, '0, '0));
        opening.push_back(mk_item(KIND_CLR_KEY, 3'b000, '0, '0));
        foreach (opening[i]) begin
            send_item(opening[i]);
        end

        // zero clamps to one tick per ms, picked up as the dividers reload
        write_rate('0);
        tx_rate = 3;
        rx_rate = 3;
        run_items(120, 97, 1'b0);

        phase_rate = '{5'd20, 5'd31, 5'd1, 5'd21, 5'd10, 5'd3,
                       TPM_W'($urandom_range(2, 19))};
        phase_len  = '{150, 120, 500, 120, 150, 150, 260};
        for (int p = 0; p < 7; p++) begin
            write_rate(phase_rate[p]);
            run_items(phase_len[p], 85, 1'b1);
        end

        wait_drained(8);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb_tick_divider_with_buzzer passed");
        end else begin
            $display("tb_tick_divider_with_buzzer failed");
        end
        $finish;
    end

endmodule
